FILE: sv/periodic_timer_table_defines.svh
// Assertion macros shared by the periodic timer table RTL.
// No dependencies; included by the top level.
`ifndef PERIODIC_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PTT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("periodic_timer_table: check failed");

// next-cycle implication, disabled during reset
`define PTT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("periodic_timer_table: check failed");

`endif

FILE: sv/ptt_pkg.sv
// Package for the periodic timer table: payload structs, command struct, codes.
// No dependencies.
package ptt_pkg;

    localparam int TIME_W   = 32;
    localparam int ENTRY_W  = 3;
    localparam int DEF_SLOTS = 8;
    localparam int CQ_DEPTH = 2;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_PAUSE = 2'd2;

    localparam logic [1:0] KIND_FIRED = 2'd0;
    localparam logic [1:0] KIND_ADDED = 2'd1;
    localparam logic [1:0] KIND_FULL  = 2'd2;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_PAUSE = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] period_ms;
        logic [TIME_W-1:0] first_due_ms;
        logic [2:0]        slot_index;
        logic              pause_flag;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [ENTRY_W-1:0] entry_index;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic              wrap;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] first;
        logic [2:0]        slot;
        logic              pause;
    } cmd_t;

endpackage

FILE: sv/ptt_front.sv
// Front end: accepts input transfers, decodes the operation, detects time wrap.
// Depends on ptt_pkg.
module ptt_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ptt_pkg::in_item_t s_data,
    output logic              cq_valid,
    input  logic              cq_ready,
    output ptt_pkg::cmd_t     cq_data
);

    logic [ptt_pkg::TIME_W-1:0] prev_reg, prev_next;
    logic                       acc;
    logic                       known;

    assign s_ready = cq_ready;
    assign acc     = s_valid && cq_ready;
    assign known   = (s_data.operation == ptt_pkg::OP_TICK) ||
                     (s_data.operation == ptt_pkg::OP_ADD) ||
                     (s_data.operation == ptt_pkg::OP_PAUSE);
    assign cq_valid = s_valid && known;

    always_comb begin
        cq_data        = '0;
        cq_data.wrap   = s_data.now_ms < prev_reg;
        cq_data.now    = s_data.now_ms;
        cq_data.period = s_data.period_ms;
        cq_data.first  = s_data.first_due_ms;
        cq_data.slot   = s_data.slot_index;
        cq_data.pause  = s_data.pause_flag;
        unique case (s_data.operation)
            ptt_pkg::OP_TICK:  cq_data.kind = ptt_pkg::CMD_TICK;
            ptt_pkg::OP_ADD:   cq_data.kind = ptt_pkg::CMD_ADD;
            ptt_pkg::OP_PAUSE: cq_data.kind = ptt_pkg::CMD_PAUSE;
            default:           cq_data.kind = ptt_pkg::CMD_TICK;
        endcase
    end

    always_comb begin
        prev_next = prev_reg;
        if (acc && s_data.operation == ptt_pkg::OP_TICK) begin
            prev_next = s_data.now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
        end else begin
            prev_reg <= prev_next;
        end
    end

endmodule

FILE: sv/ptt_cmd_fifo.sv
// Short command queue between front end and back end.
// Depends on ptt_pkg.
module ptt_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  ptt_pkg::cmd_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ptt_pkg::cmd_t out_data
);

    localparam int AW = (ptt_pkg::CQ_DEPTH > 1) ? $clog2(ptt_pkg::CQ_DEPTH) : 1;
    localparam int NW = $clog2(ptt_pkg::CQ_DEPTH + 1);
    localparam logic [NW-1:0] FULL_N = NW'(ptt_pkg::CQ_DEPTH);
    localparam logic [AW-1:0] LAST_P = AW'(ptt_pkg::CQ_DEPTH - 1);

    ptt_pkg::cmd_t   q_mem [ptt_pkg::CQ_DEPTH];
    logic [AW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [NW-1:0]   num_reg, num_next;
    logic            push, pop;

    assign in_ready  = num_reg != FULL_N;
    assign out_valid = num_reg != '0;
    assign out_data  = q_mem[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_next  = push ? ((wr_reg == LAST_P) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = pop  ? ((rd_reg == LAST_P) ? '0 : rd_reg + 1'b1) : rd_reg;
        num_next = num_reg;
        if (push && !pop) begin
            num_next = num_reg + 1'b1;
        end else if (pop && !push) begin
            num_next = num_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            num_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            num_reg <= num_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_reg] <= in_data;
        end
    end

endmodule

FILE: sv/ptt_back.sv
// Back end: timer entry memories, entry walk for ticks, add and pause, result register.
// Depends on ptt_pkg.
module ptt_back #(
    parameter int SLOTS = ptt_pkg::DEF_SLOTS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  ptt_pkg::cmd_t              cmd,
    output logic                       m_valid,
    input  logic                       m_ready,
    output ptt_pkg::out_item_t         m_data,
    output logic [$clog2(SLOTS+1)-1:0] entry_cnt
);

    localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int CMPW = (CW > ptt_pkg::ENTRY_W) ? CW : ptt_pkg::ENTRY_W;
    localparam int TW   = ptt_pkg::TIME_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(SLOTS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [TW-1:0] due_mem [SLOTS];
    logic [TW-1:0] ivl_mem [SLOTS];
    logic          aw_mem  [SLOTS];
    logic          pz_mem  [SLOTS];

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          ev_vld_reg, ev_vld_next;
    logic          pend_vld_reg, pend_vld_next;
    logic [IW-1:0] pend_idx_reg, pend_idx_next;
    logic          out_vld_reg, out_vld_next;
    ptt_pkg::out_item_t out_data_reg;
    ptt_pkg::cmd_t cur_reg;
    logic [IW-1:0] ev_idx_reg;
    logic [TW-1:0] due_q, ivl_q;
    logic          aw_q, pz_q;

    logic          out_free, push, cur_load, rd_en, more, ev_ok, adv, slot_ok;
    ptt_pkg::out_item_t push_data;
    logic [IW-1:0] rd_addr, wr_addr;
    logic          due_we, ivl_we, aw_we, pz_we;
    logic [TW-1:0] due_wd;
    logic          aw_wd, pz_wd;

    logic [TW-1:0] due_w, new_due;
    logic          aw_w, is_due, fire, new_aw;
    logic [TW:0]   sum;

    assign out_free  = !out_vld_reg || m_ready;
    assign m_valid   = out_vld_reg;
    assign m_data    = out_data_reg;
    assign entry_cnt = cnt_reg;
    assign rd_addr   = rd_idx_reg[IW-1:0];
    assign more      = rd_idx_reg < cnt_reg;
    assign slot_ok   = CMPW'(cmd.slot) < CMPW'(cnt_reg);

    // per-entry tick update
    always_comb begin
        aw_w    = cur_reg.wrap ? 1'b0 : aw_q;
        due_w   = (cur_reg.wrap && !aw_q) ? '0 : due_q;
        is_due  = !aw_w && (cur_reg.now >= due_w);
        sum     = {1'b0, due_w} + {1'b0, ivl_q};
        new_due = is_due ? sum[TW-1:0] : due_w;
        new_aw  = is_due ? (!cur_reg.wrap && sum[TW]) : aw_w;
        fire    = is_due && !pz_q;
    end

    assign ev_ok = !(fire && pend_vld_reg && !out_free);
    assign adv   = !ev_vld_reg || ev_ok;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rd_idx_next   = rd_idx_reg;
        ev_vld_next   = ev_vld_reg;
        pend_vld_next = pend_vld_reg;
        pend_idx_next = pend_idx_reg;
        cmd_ready     = 1'b0;
        cur_load      = 1'b0;
        rd_en         = 1'b0;
        push          = 1'b0;
        push_data     = '0;
        wr_addr       = ev_idx_reg;
        due_we        = 1'b0;
        ivl_we        = 1'b0;
        aw_we         = 1'b0;
        pz_we         = 1'b0;
        due_wd        = new_due;
        aw_wd         = new_aw;
        pz_wd         = cmd.pause;
        unique case (state_reg)
            ST_IDLE: begin
                cmd_ready = (cmd.kind != ptt_pkg::CMD_ADD) || out_free;
                if (cmd_valid && cmd_ready) begin
                    unique case (cmd.kind)
                        ptt_pkg::CMD_TICK: begin
                            cur_load    = 1'b1;
                            rd_idx_next = '0;
                            if (cnt_reg != '0) begin
                                state_next = ST_WALK;
                            end
                        end
                        ptt_pkg::CMD_ADD: begin
                            push = 1'b1;
                            if (cnt_reg < CNT_MAX) begin
                                wr_addr   = cnt_reg[IW-1:0];
                                due_we    = 1'b1;
                                ivl_we    = 1'b1;
                                aw_we     = 1'b1;
                                pz_we     = 1'b1;
                                due_wd    = cmd.first;
                                aw_wd     = 1'b0;
                                cnt_next  = cnt_reg + 1'b1;
                                push_data.kind        = ptt_pkg::KIND_ADDED;
                                push_data.entry_index = ptt_pkg::ENTRY_W'(cnt_reg);
                            end else begin
                                push_data.kind = ptt_pkg::KIND_FULL;
                            end
                            push_data.last = 1'b1;
                        end
                        ptt_pkg::CMD_PAUSE: begin
                            wr_addr = IW'(cmd.slot);
                            pz_we   = slot_ok;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                rd_en = adv && more;
                if (adv) begin
                    ev_vld_next = more;
                end
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (ev_vld_reg && ev_ok) begin
                    due_we = 1'b1;
                    aw_we  = 1'b1;
                    if (fire) begin
                        push                  = pend_vld_reg;
                        push_data.kind        = ptt_pkg::KIND_FIRED;
                        push_data.entry_index = ptt_pkg::ENTRY_W'(pend_idx_reg);
                        pend_idx_next         = ev_idx_reg;
                        pend_vld_next         = 1'b1;
                    end
                end
                if (!ev_vld_reg && !more) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!pend_vld_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    push                  = 1'b1;
                    push_data.kind        = ptt_pkg::KIND_FIRED;
                    push_data.entry_index = ptt_pkg::ENTRY_W'(pend_idx_reg);
                    push_data.last        = 1'b1;
                    pend_vld_next         = 1'b0;
                    state_next            = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (push) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            rd_idx_reg   <= '0;
            ev_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_idx_reg   <= rd_idx_next;
            ev_vld_reg   <= ev_vld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg <= pend_idx_next;
        if (push) begin
            out_data_reg <= push_data;
        end
        if (cur_load) begin
            cur_reg <= cmd;
        end
        if (rd_en) begin
            ev_idx_reg <= rd_addr;
            due_q      <= due_mem[rd_addr];
            ivl_q      <= ivl_mem[rd_addr];
            aw_q       <= aw_mem[rd_addr];
            pz_q       <= pz_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (due_we) begin
            due_mem[wr_addr] <= due_wd;
        end
        if (ivl_we) begin
            ivl_mem[wr_addr] <= cmd.period;
        end
        if (aw_we) begin
            aw_mem[wr_addr] <= aw_wd;
        end
        if (pz_we) begin
            pz_mem[wr_addr] <= pz_wd;
        end
    end

endmodule

FILE: sv/periodic_timer_table.sv
// Top level of the periodic timer table: front end, command queue, back end.
// Depends on ptt_pkg, ptt_front, ptt_cmd_fifo, ptt_back, periodic_timer_table_defines.svh.
//
// Usage:
//   s_valid/s_ready/s_data carry operations: tick (current ms time), add timer,
//   set pause. m_valid/m_ready/m_data carry results: fired index, added index,
//   or table full, with last marking the final result of one operation.
//   A two-entry command queue decouples input acceptance from execution.
//   Add: the command passes through the command queue and its result is
//   registered in the output register. Set pause: applied from the queue,
//   no result. Unknown operation codes are dropped.
//   Tick: entries are walked one per cycle through the entry memories while
//   no fired entry is held back by a busy output register; each entry is read
//   into registers, updated and written back; a fired entry is held pending
//   before it moves to the output register. Ticks yielding no fired entry
//   produce no result.
//   Reset clears the entry count and previous time; the memories are not
//   cleared, an entry is only read after an add has written it.
//   When m_ready is low the output register holds its result; the walk keeps
//   one fired entry pending and stalls at the next fired entry until the
//   output register frees, and the queue then fills and drops s_ready.
`include "periodic_timer_table_defines.svh"

module periodic_timer_table #(
    parameter int SLOTS = ptt_pkg::DEF_SLOTS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ptt_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ptt_pkg::out_item_t m_data
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(SLOTS);

    logic          fq_valid, fq_ready, cq_valid, cq_ready;
    ptt_pkg::cmd_t fq_data, cq_data;
    logic [CW-1:0] entry_cnt;
    logic [ptt_pkg::ENTRY_W-1:0] exp_idx;

    ptt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .cq_valid (fq_valid),
        .cq_ready (fq_ready),
        .cq_data  (fq_data)
    );

    ptt_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (cq_valid),
        .out_ready (cq_ready),
        .out_data  (cq_data)
    );

    ptt_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cq_valid),
        .cmd_ready (cq_ready),
        .cmd       (cq_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .entry_cnt (entry_cnt)
    );

    assign exp_idx = ptt_pkg::ENTRY_W'(entry_cnt - 1'b1);

    `PTT_ASSERT_IMPL(a_cnt_range, aclk, aresetn, 1'b1, entry_cnt <= CNT_MAX)
    `PTT_ASSERT_IMPL(a_full_cnt, aclk, aresetn, m_valid && m_data.kind == ptt_pkg::KIND_FULL, entry_cnt == CNT_MAX)
    `PTT_ASSERT_IMPL(a_added_idx, aclk, aresetn, m_valid && m_data.kind == ptt_pkg::KIND_ADDED, m_data.entry_index == exp_idx && m_data.last)
    `PTT_ASSERT_NEXT(a_cnt_grow, aclk, aresetn, !(cq_valid && cq_ready && cq_data.kind == ptt_pkg::CMD_ADD), $stable(entry_cnt))

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for periodic_timer_table: random bursty ticks, adds and pauses.
// Depends on ptt_pkg and the periodic_timer_table RTL; a local timer-table predictor checks results.
module tb;

    localparam int SLOTS        = ptt_pkg::DEF_SLOTS;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 150;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

    class timer_scoreboard;
        logic [ptt_pkg::TIME_W-1:0] last_now;
        int                         entry_count;
        logic [ptt_pkg::TIME_W-1:0] due_ms [SLOTS];
        logic [ptt_pkg::TIME_W-1:0] period [SLOTS];
        bit                         wait_wrap [SLOTS];
        bit                         held [SLOTS];
        ptt_pkg::out_item_t         expected [$];
        int mismatches, items, ticks, wraps, rejected, results, fired;

        function new();
            last_now    = '0;
            entry_count = 0;
            mismatches  = 0;
            items       = 0;
            ticks       = 0;
            wraps       = 0;
            rejected    = 0;
            results     = 0;
            fired       = 0;
        endfunction

        function void note_transfer(ptt_pkg::in_item_t it);
            ptt_pkg::out_item_t       pend;
            bit                       have;
            bit                       rolled;
            logic [ptt_pkg::TIME_W:0] sum;
            items++;
            case (it.operation)
                ptt_pkg::OP_TICK: begin
                    ticks++;
                    rolled = it.now_ms < last_now;
                    if (rolled) wraps++;
                    last_now = it.now_ms;
                    have = 1'b0;
                    for (int i = 0; i < entry_count; i++) begin
                        if (rolled) begin
                            if (wait_wrap[i]) wait_wrap[i] = 1'b0;
                            else due_ms[i] = '0;
                        end
                        if (!wait_wrap[i] && it.now_ms >= due_ms[i]) begin
                            if (!held[i]) begin
                                if (have) expected.push_back(pend);
                                pend.kind        = ptt_pkg::KIND_FIRED;
                                pend.entry_index = ptt_pkg::ENTRY_W'(i);
                                pend.last        = 1'b0;
                                have             = 1'b1;
                            end
                            sum          = {1'b0, due_ms[i]} + {1'b0, period[i]};
                            due_ms[i]    = sum[ptt_pkg::TIME_W-1:0];
                            wait_wrap[i] = !rolled && sum[ptt_pkg::TIME_W];
                        end
                    end
                    if (have) begin
                        pend.last = 1'b1;
                        expected.push_back(pend);
                    end
                end
                ptt_pkg::OP_ADD: begin
                    if (entry_count < SLOTS) begin
                        due_ms[entry_count]    = it.first_due_ms;
                        period[entry_count]    = it.period_ms;
                        held[entry_count]      = it.pause_flag;
                        wait_wrap[entry_count] = 1'b0;
                        pend.kind        = ptt_pkg::KIND_ADDED;
                        pend.entry_index = ptt_pkg::ENTRY_W'(entry_count);
                        entry_count++;
                    end else begin
                        rejected++;
                        pend.kind        = ptt_pkg::KIND_FULL;
                        pend.entry_index = '0;
                    end
                    pend.last = 1'b1;
                    expected.push_back(pend);
                end
                ptt_pkg::OP_PAUSE: begin
                    if (it.slot_index < entry_count) held[it.slot_index] = it.pause_flag;
                end
                default: ;
            endcase
        endfunction

        function void check_result(ptt_pkg::out_item_t got);
            ptt_pkg::out_item_t want;
            results++;
            if (got.kind == ptt_pkg::KIND_FIRED) fired++;
            if (expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d unexpected: kind %0d idx %0d last %0d",
                             results, got.kind, got.entry_index, got.last);
                return;
            end
            want = expected.pop_front();
            if (got.kind != want.kind || got.entry_index != want.entry_index ||
                got.last != want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: want kind %0d idx %0d last %0d, got kind %0d idx %0d last %0d",
                             results, want.kind, want.entry_index, want.last,
                             got.kind, got.entry_index, got.last);
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    ptt_pkg::in_item_t  s_data;
    logic               m_valid;
    logic               m_ready;
    ptt_pkg::out_item_t m_data;

    timer_scoreboard sb = new();

    int       burst_left = 0;
    int       hold_left  = 0;
    bit       hold_done  = 1'b0;
    int       phase_left = 0;
    rx_mode_t rx_mode    = RX_OPEN;

    periodic_timer_table dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result side: check, then pick next ready from the current stall pattern
    always @(posedge aclk) begin
        if (m_valid && m_ready) sb.check_result(m_data);
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && sb.results >= 40) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                rx_mode    = rx_mode_t'($urandom_range(0, 2));
                phase_left = $urandom_range(8, 60);
            end
            phase_left--;
            case (rx_mode)
                RX_OPEN: m_ready <= 1'b1;
                RX_COIN: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle = 0;
            else idle++;
        end
        $display("periodic_timer_table: mismatch");
        $finish;
    end

    function automatic ptt_pkg::in_item_t noise_item(logic [1:0] op);
        ptt_pkg::in_item_t it;
        it.operation    = op;
        it.now_ms       = $urandom;
        it.period_ms    = $urandom;
        it.first_due_ms = $urandom;
        it.slot_index   = 3'($urandom_range(0, 7));
        it.pause_flag   = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic send_item(ptt_pkg::in_item_t it);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_transfer(it);
    endtask

    task automatic tick(logic [ptt_pkg::TIME_W-1:0] now);
        ptt_pkg::in_item_t it;
        it        = noise_item(ptt_pkg::OP_TICK);
        it.now_ms = now;
        send_item(it);
    endtask

    task automatic add_timer(logic [ptt_pkg::TIME_W-1:0] per,
                             logic [ptt_pkg::TIME_W-1:0] first, logic flag);
        ptt_pkg::in_item_t it;
        it              = noise_item(ptt_pkg::OP_ADD);
        it.period_ms    = per;
        it.first_due_ms = first;
        it.pause_flag   = flag;
        send_item(it);
    endtask

    task automatic set_pause(logic [2:0] slot, logic flag);
        ptt_pkg::in_item_t it;
        it            = noise_item(ptt_pkg::OP_PAUSE);
        it.slot_index = slot;
        it.pause_flag = flag;
        send_item(it);
    endtask

    initial begin
        logic [ptt_pkg::TIME_W-1:0] clock_ms;
        int                         pick;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table, ignored codes, pause beyond the last entry
        tick(32'd0);
        send_item(noise_item(OP_UNUSED));
        set_pause(3'd0, 1'b1);
        add_timer(32'd5, 32'd0, 1'b0);
        add_timer(32'hFFFF_FFFF, 32'd3, 1'b1);
        add_timer(32'd0, 32'hFFFF_FFFF, 1'b0);
        set_pause(3'd3, 1'b1);
        add_timer(32'd7, 32'd10, 1'b0);
        tick(32'd0);
        tick(32'hFFFF_FFFF);
        set_pause(3'd1, 1'b0);
        tick(32'd2);
        tick(32'd2);
        add_timer(32'd1, 32'd0, 1'b0);
        add_timer(32'd3, 32'd1, 1'b1);
        add_timer(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        add_timer(32'd13, 32'd20, 1'b0);
        add_timer(32'd9, 32'd9, 1'b0);
        tick(32'hFFFF_FFF0);
        tick(32'd0);
        set_pause(3'd7, 1'b1);
        tick(32'd100);

        clock_ms = 32'd100;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)      clock_ms = clock_ms + $urandom_range(0, 9);
                else if (pick < 78) clock_ms = $urandom_range(0, 15);
                else if (pick < 86) clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
                else if (pick < 93) clock_ms = $urandom;
                tick(clock_ms);
            end else if (pick < 78) begin
                send_item(noise_item(ptt_pkg::OP_ADD));
            end else if (pick < 95) begin
                send_item(noise_item(ptt_pkg::OP_PAUSE));
            end else begin
                send_item(noise_item(OP_UNUSED));
            end
        end
        s_valid <= 1'b0;

        while (sb.expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d transfers in: %0d ticks (%0d wrapped), %0d adds refused as full",
                 sb.items, sb.ticks, sb.wraps, sb.rejected);
        $display("checked %0d results out (%0d timer firings), %0d mismatched",
                 sb.results, sb.fired, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected.size() == 0) begin
            $display("periodic_timer_table: match");
        end else begin
            $display("periodic_timer_table: mismatch");
        end
        $finish;
    end
endmodule
